@@ src/arpc_pkg.sv @@
package arpc_pkg;

    localparam logic [1:0] ACT_ARP  = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] OUT_NONE  = 3'd0;
    localparam logic [2:0] OUT_SEND  = 3'd1;
    localparam logic [2:0] OUT_REQ   = 3'd2;
    localparam logic [2:0] OUT_REPLY = 3'd3;
    localparam logic [2:0] OUT_DUP   = 3'd4;
    localparam logic [2:0] OUT_BAD   = 3'd5;
    localparam logic [2:0] OUT_FULL  = 3'd6;

    localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
    localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
    localparam logic [1:0] REG_CACHE_TO  = 2'd2;
    localparam logic [1:0] REG_PEND_TO   = 2'd3;

    localparam logic [47:0] BCAST_MAC = {6{8'hFF}};
    localparam logic [15:0] AGE_MAX   = 16'hFFFF;
    localparam logic [10:0] MIN_LEN   = 11'd28;

    // classified command from front to back
    localparam logic [1:0] CMD_NOP  = 2'd0;
    localparam logic [1:0] CMD_LRN  = 2'd1;
    localparam logic [1:0] CMD_SEND = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] frame_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] arp_opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] tgt_ip;
        logic [31:0] next_hop_ip;
        logic [7:0]  packet_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
        logic [7:0]  out_handle;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        bad;
        logic        is_req;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] tgt_ip;
        logic [7:0]  handle;
    } cmd_t;

endpackage

@@ src/arp_cache_resolver.sv @@
// ARP cache and responder for IPv4 over Ethernet.
// Input channel: push/full queue carrying one in_item; action selects a
// received ARP packet, an outbound IP packet or an aging tick.
// Result channel: empty/pop queue; every accepted item gives exactly one
// result item (outcome, dest_mac, dest_ip, out_handle), in order.
// Configuration: APB-style port, 64-bit data, registers at 8*i:
// local_ip, local_mac, cache_timeout, pending_timeout. pready is tied high.
// A front stage classifies items into a two-deep command queue; the back
// sequencer scans the cache one entry a cycle, then the pending table one
// entry a cycle, then applies the item. It takes a new command only once
// idle again, after the last item is applied; invalid ARP packets and
// unused actions skip the scans.
// Reset empties both tables and queues and sets timeouts to 60 and 1.
// When the receiver stalls, one result waits in the output register, the
// next item finishes its scans and holds until that register frees, the
// front queue fills with two more items, and full then rises.
module arp_cache_resolver #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  arpc_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output arpc_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic           cmd_valid, cmd_take, res_valid;
    arpc_pkg::cmd_t cmd;
    logic [31:0]    local_ip_reg;
    logic [47:0]    local_mac_reg;
    logic [15:0]    cache_to_reg, pend_to_reg;
    logic           wr;
    logic [1:0]     ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:3];
    assign empty  = !res_valid;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
            cache_to_reg  <= 16'd60;
            pend_to_reg   <= 16'd1;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                arpc_pkg::REG_LOCAL_IP:  local_ip_reg  <= pwdata[31:0];
                arpc_pkg::REG_LOCAL_MAC: local_mac_reg <= pwdata[47:0];
                arpc_pkg::REG_CACHE_TO:  cache_to_reg  <= pwdata[15:0];
                arpc_pkg::REG_PEND_TO:   pend_to_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (ridx)
            arpc_pkg::REG_LOCAL_IP:  prdata = {32'd0, local_ip_reg};
            arpc_pkg::REG_LOCAL_MAC: prdata = {16'd0, local_mac_reg};
            arpc_pkg::REG_CACHE_TO:  prdata = {48'd0, cache_to_reg};
            arpc_pkg::REG_PEND_TO:   prdata = {48'd0, pend_to_reg};
            default:                 prdata = '0;
        endcase
    end

    arpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    arpc_back #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_take        (cmd_take),
        .cmd             (cmd),
        .local_ip        (local_ip_reg),
        .cache_timeout   (cache_to_reg),
        .pending_timeout (pend_to_reg),
        .res_valid       (res_valid),
        .res_take        (pop),
        .res             (out_item)
    );

endmodule

@@ src/arpc_front.sv @@
module arpc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  arpc_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output arpc_pkg::cmd_t    cmd
);

    // two-entry queue of classified commands
    arpc_pkg::cmd_t q_reg [2];
    logic           rd_ptr_reg, wr_ptr_reg;
    logic [1:0]     cnt_reg;
    arpc_pkg::cmd_t cls;
    logic           wr_en, rd_en;

    // classify the incoming item
    always_comb
    begin
        cls        = '0;
        cls.ip     = in_item.src_ip;
        cls.mac    = in_item.src_mac;
        cls.tgt_ip = in_item.tgt_ip;
        cls.handle = in_item.packet_handle;
        cls.is_req = (in_item.arp_opcode == 16'd1);
        unique case (in_item.action)
            arpc_pkg::ACT_ARP:
            begin
                cls.cmd = arpc_pkg::CMD_LRN;
                cls.bad = (in_item.frame_len < arpc_pkg::MIN_LEN) ||
                          (in_item.hw_type != 16'd1) ||
                          (in_item.proto_type != 16'h0800) ||
                          (in_item.hw_addr_len != 8'd6) ||
                          (in_item.proto_addr_len != 8'd4) ||
                          ((in_item.arp_opcode != 16'd1) &&
                           (in_item.arp_opcode != 16'd2));
            end
            arpc_pkg::ACT_SEND:
            begin
                cls.cmd = arpc_pkg::CMD_SEND;
                cls.ip  = in_item.next_hop_ip;
            end
            arpc_pkg::ACT_TICK: cls.cmd = arpc_pkg::CMD_TICK;
            default:            cls.cmd = arpc_pkg::CMD_NOP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign wr_en     = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign rd_en     = cmd_take && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // hold queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en) wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) q_reg[wr_ptr_reg] <= cls;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("front queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !rd_en)
        else $error("front queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("front queue count slip");

endmodule

@@ src/arpc_back.sv @@
module arpc_back #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  arpc_pkg::cmd_t    cmd,
    input  logic [31:0]       local_ip,
    input  logic [15:0]       cache_timeout,
    input  logic [15:0]       pending_timeout,
    output logic              res_valid,
    input  logic              res_take,
    output arpc_pkg::out_item_t res
);

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam logic [CW:0] CLAST = (CW+1)'(CACHE_ENTRIES - 1);
    localparam logic [PW:0] PLAST = (PW+1)'(PENDING_ENTRIES - 1);
    localparam logic [CW:0] CEND  = (CW+1)'(CACHE_ENTRIES);
    localparam logic [CW:0] CONE  = (CW+1)'(1);
    localparam logic [PW:0] PONE  = (PW+1)'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CSCAN = 3'd1;
    localparam logic [2:0] ST_PSCAN = 3'd2;
    localparam logic [2:0] ST_DO    = 3'd3;

    // tables held in flip-flops, scanned one entry a cycle
    logic [31:0] c_ip_reg  [CACHE_ENTRIES];
    logic [47:0] c_mac_reg [CACHE_ENTRIES];
    logic [15:0] c_age_reg [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] c_val_reg;
    logic [31:0] p_ip_reg  [PENDING_ENTRIES];
    logic [7:0]  p_hnd_reg [PENDING_ENTRIES];
    logic [15:0] p_age_reg [PENDING_ENTRIES];
    logic [PENDING_ENTRIES-1:0] p_val_reg;

    logic [2:0]          state_reg;
    arpc_pkg::cmd_t      cur_reg;
    logic [CW:0]         ci_reg;
    logic [PW:0]         pi_reg;
    logic                c_hit_reg, c_free_ok_reg;
    logic [CW-1:0]       c_hit_idx_reg, c_free_reg, c_old_reg;
    logic [15:0]         c_old_age_reg;
    logic                p_hit_reg, p_free_ok_reg;
    logic [PW-1:0]       p_hit_idx_reg, p_free_reg;
    arpc_pkg::out_item_t res_reg;
    logic                res_valid_reg;

    logic [CW-1:0] ci;
    logic [PW-1:0] pi;
    logic [15:0]   c_inc, p_inc;
    logic [CW-1:0] lslot;
    logic          out_free;
    logic          fire;
    arpc_pkg::out_item_t res_next;

    assign ci        = ci_reg[CW-1:0];
    assign pi        = pi_reg[PW-1:0];
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign c_inc     = (c_age_reg[ci] < arpc_pkg::AGE_MAX) ? c_age_reg[ci] + 16'd1
                                                            : c_age_reg[ci];
    assign p_inc     = (p_age_reg[pi] < arpc_pkg::AGE_MAX) ? p_age_reg[pi] + 16'd1
                                                            : p_age_reg[pi];
    assign lslot     = c_hit_reg ? c_hit_idx_reg : (c_free_ok_reg ? c_free_reg : c_old_reg);
    assign out_free  = !res_valid_reg || res_take;
    assign fire      = (state_reg == ST_DO) && out_free;

    // build the result of the current command from the scan outcome
    always_comb
    begin
        res_next = '0;
        priority if (cur_reg.cmd == arpc_pkg::CMD_LRN && cur_reg.bad)
            res_next.outcome = arpc_pkg::OUT_BAD;
        else if (cur_reg.cmd == arpc_pkg::CMD_LRN)
        begin
            if (p_hit_reg)
            begin
                res_next.outcome    = arpc_pkg::OUT_SEND;
                res_next.dest_mac   = cur_reg.mac;
                res_next.out_handle = p_hnd_reg[p_hit_idx_reg];
            end
            else if (cur_reg.is_req && cur_reg.tgt_ip == local_ip)
            begin
                res_next.outcome  = arpc_pkg::OUT_REPLY;
                res_next.dest_mac = cur_reg.mac;
                res_next.dest_ip  = cur_reg.ip;
            end
        end
        else if (cur_reg.cmd == arpc_pkg::CMD_SEND)
        begin
            res_next.out_handle = cur_reg.handle;
            if (c_hit_reg)
            begin
                res_next.outcome  = arpc_pkg::OUT_SEND;
                res_next.dest_mac = c_mac_reg[c_hit_idx_reg];
            end
            else if (p_hit_reg)
                res_next.outcome = arpc_pkg::OUT_DUP;
            else if (!p_free_ok_reg)
                res_next.outcome = arpc_pkg::OUT_FULL;
            else
            begin
                res_next.outcome    = arpc_pkg::OUT_REQ;
                res_next.dest_mac   = arpc_pkg::BCAST_MAC;
                res_next.dest_ip    = cur_reg.ip;
                res_next.out_handle = '0;
            end
        end
        else
            res_next.outcome = arpc_pkg::OUT_NONE;
    end

    // sequence one command: cache scan, pending scan (both skipped when bad or no-op), apply and deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_val_reg     <= '0;
            p_val_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            ci_reg        <= '0;
            pi_reg        <= '0;
            for (int k = 0; k < CACHE_ENTRIES; k++) c_age_reg[k] <= '0;
            for (int k = 0; k < PENDING_ENTRIES; k++) p_age_reg[k] <= '0;
        end
        else
        begin
            // load the output register, or drop the item once taken
            if (fire)
            begin
                res_reg       <= res_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_take && res_valid_reg)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg       <= cmd;
                        ci_reg        <= '0;
                        pi_reg        <= '0;
                        c_hit_reg     <= 1'b0;
                        c_free_ok_reg <= 1'b0;
                        c_old_reg     <= '0;
                        c_old_age_reg <= c_age_reg[0];
                        p_hit_reg     <= 1'b0;
                        p_free_ok_reg <= 1'b0;
                        state_reg     <= (cmd.cmd == arpc_pkg::CMD_NOP || cmd.bad)
                                         ? ST_DO : ST_CSCAN;
                    end
                end
                ST_CSCAN:
                begin
                    if (cur_reg.cmd == arpc_pkg::CMD_TICK)
                    begin
                        if (c_val_reg[ci])
                        begin
                            c_age_reg[ci] <= c_inc;
                            if (c_inc >= cache_timeout) c_val_reg[ci] <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (c_val_reg[ci] && c_ip_reg[ci] == cur_reg.ip && !c_hit_reg)
                        begin
                            c_hit_reg     <= 1'b1;
                            c_hit_idx_reg <= ci;
                        end
                        if (!c_val_reg[ci] && !c_free_ok_reg)
                        begin
                            c_free_ok_reg <= 1'b1;
                            c_free_reg    <= ci;
                        end
                        if (c_age_reg[ci] > c_old_age_reg)
                        begin
                            c_old_age_reg <= c_age_reg[ci];
                            c_old_reg     <= ci;
                        end
                    end
                    ci_reg <= ci_reg + CONE;
                    if (ci_reg == CLAST) state_reg <= ST_PSCAN;
                end
                ST_PSCAN:
                begin
                    if (cur_reg.cmd == arpc_pkg::CMD_TICK)
                    begin
                        if (p_val_reg[pi])
                        begin
                            p_age_reg[pi] <= p_inc;
                            if (p_inc >= pending_timeout) p_val_reg[pi] <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (p_val_reg[pi] && p_ip_reg[pi] == cur_reg.ip && !p_hit_reg)
                        begin
                            p_hit_reg     <= 1'b1;
                            p_hit_idx_reg <= pi;
                        end
                        if (!p_val_reg[pi] && !p_free_ok_reg)
                        begin
                            p_free_ok_reg <= 1'b1;
                            p_free_reg    <= pi;
                        end
                    end
                    pi_reg <= pi_reg + PONE;
                    if (pi_reg == PLAST) state_reg <= ST_DO;
                end
                ST_DO:
                begin
                    // hold until the output register is free, then apply
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (cur_reg.cmd == arpc_pkg::CMD_LRN && !cur_reg.bad)
                        begin
                            c_ip_reg[lslot]  <= cur_reg.ip;
                            c_mac_reg[lslot] <= cur_reg.mac;
                            c_age_reg[lslot] <= '0;
                            c_val_reg[lslot] <= 1'b1;
                            if (p_hit_reg) p_val_reg[p_hit_idx_reg] <= 1'b0;
                        end
                        else if (cur_reg.cmd == arpc_pkg::CMD_SEND && !c_hit_reg &&
                                 !p_hit_reg && p_free_ok_reg)
                        begin
                            p_ip_reg[p_free_reg]  <= cur_reg.ip;
                            p_hnd_reg[p_free_reg] <= cur_reg.handle;
                            p_age_reg[p_free_reg] <= '0;
                            p_val_reg[p_free_reg] <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (state_reg != ST_IDLE))
        else $error("command taken without starting work");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DO && res_valid_reg && !res_take) |=>
        (state_reg == ST_DO && $stable(res_reg)))
        else $error("result overwritten while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (ci_reg <= CEND))
        else $error("cache scan index out of range");

endmodule
